// ===== hdl/nearest_neighbor_scale_address_defines.svh =====
// Assertion macros shared by the nearest-neighbor scale address design.
`ifndef NEAREST_NEIGHBOR_SCALE_ADDRESS_DEFINES_SVH
`define NEAREST_NEIGHBOR_SCALE_ADDRESS_DEFINES_SVH

// Same-cycle implication, checked on every rising edge out of reset.
`define NNSA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("nnsa assertion failed");

// Next-cycle implication, checked on every rising edge out of reset.
`define NNSA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("nnsa assertion failed");

`endif

// ===== hdl/nnsa_pkg.sv =====
// Package with widths, word types and shared helpers of the scale address pipeline.
`timescale 1ns / 1ps
`default_nettype none

package nnsa_pkg;

  localparam int MAX_DIM       = 4096;
  localparam int CHROMA_VSHIFT = 1;
  localparam int PLANE_COUNT   = 3;

  localparam int COORD_W    = 12;
  localparam int DIM_W      = 13;
  localparam int STRIDE_W   = 14;
  localparam int OFFSET_W   = 25;
  localparam int PLANE_W    = 2;
  localparam int PROD_W     = COORD_W + DIM_W;
  localparam int MUL_W      = COORD_W + STRIDE_W;
  localparam int SUM_W      = MUL_W + 1;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = STRIDE_W;

  // Restoring divider: quotient bits resolved per stage and stage count.
  localparam int DIV_BITS   = 2;
  localparam int DIV_STAGES = COORD_W / DIV_BITS;
  // Front stage, divider stages, stride multiply stage, output stage.
  localparam int PIPE_DEPTH = DIV_STAGES + 3;

  localparam logic [COORD_W-1:0]  COORD_SAT  = COORD_W'(MAX_DIM - 1);
  localparam logic [OFFSET_W-1:0] OFFSET_MAX = {OFFSET_W{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SOURCE_WIDTH,
    CFG_SOURCE_HEIGHT,
    CFG_TARGET_WIDTH,
    CFG_TARGET_HEIGHT,
    CFG_SOURCE_LUMA_STRIDE,
    CFG_SOURCE_CHROMA_STRIDE,
    CFG_TARGET_LUMA_STRIDE,
    CFG_TARGET_CHROMA_STRIDE
  } cfg_idx_e;

  typedef struct packed {
    logic [COORD_W-1:0] out_col;
    logic [COORD_W-1:0] out_row;
    logic [PLANE_W-1:0] plane_index;
  } in_word_t;

  typedef struct packed {
    logic [COORD_W-1:0]  src_col;
    logic [COORD_W-1:0]  src_row;
    logic [OFFSET_W-1:0] src_offset;
    logic [OFFSET_W-1:0] dst_offset;
    logic [PLANE_W-1:0]  plane_echo;
    logic                out_of_range;
  } out_word_t;

  typedef struct packed {
    logic [DIM_W-1:0]    source_width;
    logic [DIM_W-1:0]    source_height;
    logic [DIM_W-1:0]    target_width;
    logic [DIM_W-1:0]    target_height;
    logic [STRIDE_W-1:0] source_luma_stride;
    logic [STRIDE_W-1:0] source_chroma_stride;
    logic [STRIDE_W-1:0] target_luma_stride;
    logic [STRIDE_W-1:0] target_chroma_stride;
  } cfg_t;

  // Everything the front stage hands on to the rest of the pipeline.
  typedef struct packed {
    logic [PROD_W-1:0]   col_prod;
    logic [DIM_W-1:0]    col_div;
    logic [PROD_W-1:0]   row_prod;
    logic [DIM_W-1:0]    row_div;
    logic [STRIDE_W-1:0] src_stride;
    logic [MUL_W-1:0]    dst_prod;
    logic [COORD_W-1:0]  col;
    logic [PLANE_W-1:0]  plane;
    logic                bad;
  } front_t;

  // Fields that ride alongside the divider.
  typedef struct packed {
    logic [STRIDE_W-1:0] src_stride;
    logic [OFFSET_W-1:0] dst_offset;
    logic [PLANE_W-1:0]  plane;
    logic                bad;
  } side_t;

  function automatic logic [OFFSET_W-1:0] sat_offset(input logic [SUM_W-1:0] v);
    if (v > SUM_W'(OFFSET_MAX)) begin
      return OFFSET_MAX;
    end
    return v[OFFSET_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== hdl/nnsa_front.sv =====
// Front stage: plane decode, range check and the three coordinate products.
`timescale 1ns / 1ps
`default_nettype none

module nnsa_front (
  input  wire logic              clk_i,
  input  wire logic              en_i,
  input  wire nnsa_pkg::in_word_t in_i,
  input  wire nnsa_pkg::cfg_t    cfg_i,
  output nnsa_pkg::front_t       front_o
);

  logic                          chroma;
  logic [nnsa_pkg::DIM_W-1:0]    in_h;
  logic [nnsa_pkg::DIM_W-1:0]    out_h;
  logic [nnsa_pkg::STRIDE_W-1:0] dst_stride;
  nnsa_pkg::front_t              front_d;
  nnsa_pkg::front_t              front_q;

  always_comb begin
    chroma     = in_i.plane_index != '0;
    in_h       = chroma ? (cfg_i.source_height >> nnsa_pkg::CHROMA_VSHIFT)
                        : cfg_i.source_height;
    out_h      = chroma ? (cfg_i.target_height >> nnsa_pkg::CHROMA_VSHIFT)
                        : cfg_i.target_height;
    dst_stride = chroma ? cfg_i.target_chroma_stride : cfg_i.target_luma_stride;

    front_d.col_prod   = nnsa_pkg::PROD_W'(in_i.out_col)
                       * nnsa_pkg::PROD_W'(cfg_i.source_width);
    front_d.col_div    = cfg_i.target_width;
    front_d.row_prod   = nnsa_pkg::PROD_W'(in_i.out_row) * nnsa_pkg::PROD_W'(in_h);
    front_d.row_div    = out_h;
    front_d.src_stride = chroma ? cfg_i.source_chroma_stride : cfg_i.source_luma_stride;
    front_d.dst_prod   = nnsa_pkg::MUL_W'(in_i.out_row) * nnsa_pkg::MUL_W'(dst_stride);
    front_d.col        = in_i.out_col;
    front_d.plane      = in_i.plane_index;
    // A zero divisor can only reach the divider on a rejected request.
    front_d.bad = ({1'b0, in_i.plane_index} >= 3'(nnsa_pkg::PLANE_COUNT))
               || ({1'b0, in_i.out_col} >= cfg_i.target_width)
               || ({1'b0, in_i.out_row} >= out_h)
               || (in_h == '0) || (out_h == '0);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      front_q <= front_d;
    end
  end

  assign front_o = front_q;

endmodule

`default_nettype wire

// ===== hdl/nnsa_divider.sv =====
// Pipelined restoring divider with saturation of the quotient to the coordinate range.
`timescale 1ns / 1ps
`default_nettype none

module nnsa_divider (
  input  wire logic [nnsa_pkg::DIV_STAGES-1:0] clk_en_i,
  input  wire logic                            clk_i,
  input  wire logic [nnsa_pkg::PROD_W-1:0]     dividend_i,
  input  wire logic [nnsa_pkg::DIM_W-1:0]      divisor_i,
  output logic [nnsa_pkg::COORD_W-1:0]         quot_o
);

  localparam int CW = nnsa_pkg::COORD_W;
  localparam int DW = nnsa_pkg::DIM_W;
  localparam int NS = nnsa_pkg::DIV_STAGES;

  logic [DW-1:0] rem_q [NS-1];
  logic [CW-1:0] low_q [NS-1];
  logic [DW-1:0] dsr_q [NS-1];
  logic [CW-1:0] quo_q [NS];
  logic          ovf_q [NS];

  for (genvar s = 0; s < NS; s++) begin : g_stage
    logic [DW-1:0] rem_in;
    logic [CW-1:0] low_in;
    logic [DW-1:0] dsr_in;
    logic [CW-1:0] quo_in;
    logic          ovf_in;
    logic [DW-1:0] rem_nx;
    logic [CW-1:0] low_nx;
    logic [CW-1:0] quo_nx;

    if (s == 0) begin : g_first
      // The quotient reaches the saturation limit when the upper dividend
      // bits already cover the divisor; otherwise they are a valid remainder.
      assign rem_in = dividend_i[nnsa_pkg::PROD_W-1:CW];
      assign low_in = dividend_i[CW-1:0];
      assign dsr_in = divisor_i;
      assign quo_in = '0;
      assign ovf_in = dividend_i[nnsa_pkg::PROD_W-1:CW] >= divisor_i;
    end else begin : g_rest
      assign rem_in = rem_q[s-1];
      assign low_in = low_q[s-1];
      assign dsr_in = dsr_q[s-1];
      assign quo_in = quo_q[s-1];
      assign ovf_in = ovf_q[s-1];
    end

    always_comb begin
      logic [DW:0] trial;
      rem_nx = rem_in;
      low_nx = low_in;
      quo_nx = quo_in;
      for (int j = 0; j < nnsa_pkg::DIV_BITS; j++) begin
        trial  = {rem_nx, low_nx[CW-1]};
        low_nx = {low_nx[CW-2:0], 1'b0};
        if (trial >= {1'b0, dsr_in}) begin
          rem_nx = DW'(trial - {1'b0, dsr_in});
          quo_nx = {quo_nx[CW-2:0], 1'b1};
        end else begin
          rem_nx = trial[DW-1:0];
          quo_nx = {quo_nx[CW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (clk_en_i[s]) begin
        quo_q[s] <= quo_nx;
        ovf_q[s] <= ovf_in;
      end
    end

    if (s < NS - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (clk_en_i[s]) begin
          rem_q[s] <= rem_nx;
          low_q[s] <= low_nx;
          dsr_q[s] <= dsr_in;
        end
      end
    end
  end

  assign quot_o = ovf_q[NS-1] ? nnsa_pkg::COORD_SAT : quo_q[NS-1];

endmodule

`default_nettype wire

// ===== hdl/nnsa_offset.sv =====
// Back end: source row times stride, offset sums with saturation, output word register.
`timescale 1ns / 1ps
`default_nettype none

module nnsa_offset (
  input  wire logic                         clk_i,
  input  wire logic [1:0]                   en_i,
  input  wire logic [nnsa_pkg::COORD_W-1:0] col_i,
  input  wire logic [nnsa_pkg::COORD_W-1:0] row_i,
  input  wire nnsa_pkg::side_t              side_i,
  output nnsa_pkg::out_word_t               out_o
);

  logic [nnsa_pkg::COORD_W-1:0] col_q;
  logic [nnsa_pkg::COORD_W-1:0] row_q;
  logic [nnsa_pkg::MUL_W-1:0]   prod_q;
  nnsa_pkg::side_t              side_q;
  nnsa_pkg::out_word_t          out_d;
  nnsa_pkg::out_word_t          out_q;

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      col_q  <= col_i;
      row_q  <= row_i;
      prod_q <= nnsa_pkg::MUL_W'(row_i) * nnsa_pkg::MUL_W'(side_i.src_stride);
      side_q <= side_i;
    end
  end

  always_comb begin
    out_d.plane_echo   = side_q.plane;
    out_d.out_of_range = side_q.bad;
    if (side_q.bad) begin
      out_d.src_col    = '0;
      out_d.src_row    = '0;
      out_d.src_offset = '0;
      out_d.dst_offset = '0;
    end else begin
      out_d.src_col    = col_q;
      out_d.src_row    = row_q;
      out_d.src_offset = nnsa_pkg::sat_offset(nnsa_pkg::SUM_W'(prod_q)
                                              + nnsa_pkg::SUM_W'(col_q));
      out_d.dst_offset = side_q.dst_offset;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      out_q <= out_d;
    end
  end

  assign out_o = out_q;

endmodule

`default_nettype wire

// ===== hdl/nearest_neighbor_scale_address.sv =====
// Top level of the nearest-neighbor scale address generator.
`timescale 1ns / 1ps
`default_nettype none

`include "nearest_neighbor_scale_address_defines.svh"

// For each output pixel coordinate and plane this block returns the nearest
// source pixel and the source and destination byte offsets. It takes one word
// per cycle while in_stall_o is low and gives one result word per input word,
// in order. The pipeline is built around the divider: a restoring divider
// resolving two quotient bits in each of six stages, with one stage of
// products in front and one stage each for the stride multiply and the offset
// sums behind it. Empty stages close up while the output is stalled, so up to
// nine words are held before the input stalls.
// Configuration writes are taken in any cycle and must only happen while the
// pipeline is empty.
module nearest_neighbor_scale_address (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire nnsa_pkg::in_word_t              in_data_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output nnsa_pkg::out_word_t                  out_data_o,
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [nnsa_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [nnsa_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  localparam int ND = nnsa_pkg::PIPE_DEPTH;
  localparam int NS = nnsa_pkg::DIV_STAGES;

  nnsa_pkg::cfg_t               cfg_q;
  logic [ND-1:0]                valid_q;
  logic [ND-1:0]                en;
  nnsa_pkg::front_t             front;
  nnsa_pkg::side_t              side_q [NS];
  nnsa_pkg::side_t              side_d;
  logic [nnsa_pkg::COORD_W-1:0] src_col;
  logic [nnsa_pkg::COORD_W-1:0] src_row;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.source_width         <= nnsa_pkg::DIM_W'(1);
      cfg_q.source_height        <= nnsa_pkg::DIM_W'(1);
      cfg_q.target_width         <= nnsa_pkg::DIM_W'(1);
      cfg_q.target_height        <= nnsa_pkg::DIM_W'(1);
      cfg_q.source_luma_stride   <= nnsa_pkg::STRIDE_W'(1);
      cfg_q.source_chroma_stride <= nnsa_pkg::STRIDE_W'(1);
      cfg_q.target_luma_stride   <= nnsa_pkg::STRIDE_W'(1);
      cfg_q.target_chroma_stride <= nnsa_pkg::STRIDE_W'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (nnsa_pkg::cfg_idx_e'(cfg_index_i))
        nnsa_pkg::CFG_SOURCE_WIDTH:
          cfg_q.source_width <= cfg_data_i[nnsa_pkg::DIM_W-1:0];
        nnsa_pkg::CFG_SOURCE_HEIGHT:
          cfg_q.source_height <= cfg_data_i[nnsa_pkg::DIM_W-1:0];
        nnsa_pkg::CFG_TARGET_WIDTH:
          cfg_q.target_width <= cfg_data_i[nnsa_pkg::DIM_W-1:0];
        nnsa_pkg::CFG_TARGET_HEIGHT:
          cfg_q.target_height <= cfg_data_i[nnsa_pkg::DIM_W-1:0];
        nnsa_pkg::CFG_SOURCE_LUMA_STRIDE:   cfg_q.source_luma_stride   <= cfg_data_i;
        nnsa_pkg::CFG_SOURCE_CHROMA_STRIDE: cfg_q.source_chroma_stride <= cfg_data_i;
        nnsa_pkg::CFG_TARGET_LUMA_STRIDE:   cfg_q.target_luma_stride   <= cfg_data_i;
        nnsa_pkg::CFG_TARGET_CHROMA_STRIDE: cfg_q.target_chroma_stride <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // A stage loads when it is empty or when the stage after it loads too.
  always_comb begin
    en[ND-1] = !valid_q[ND-1] || !out_stall_i;
    for (int k = ND - 2; k >= 0; k--) begin
      en[k] = !valid_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (en[0]) begin
        valid_q[0] <= in_valid_i;
      end
      for (int k = 1; k < ND; k++) begin
        if (en[k]) begin
          valid_q[k] <= valid_q[k-1];
        end
      end
    end
  end

  assign in_stall_o  = !en[0];
  assign out_valid_o = valid_q[ND-1];

  nnsa_front u_front (
    .clk_i   (clk_i),
    .en_i    (en[0]),
    .in_i    (in_data_i),
    .cfg_i   (cfg_q),
    .front_o (front)
  );

  nnsa_divider u_div_col (
    .clk_en_i   (en[NS:1]),
    .clk_i      (clk_i),
    .dividend_i (front.col_prod),
    .divisor_i  (front.col_div),
    .quot_o     (src_col)
  );

  nnsa_divider u_div_row (
    .clk_en_i   (en[NS:1]),
    .clk_i      (clk_i),
    .dividend_i (front.row_prod),
    .divisor_i  (front.row_div),
    .quot_o     (src_row)
  );

  // The destination offset is finished in the first divider stage and then
  // rides along with the plane, the reject flag and the source stride.
  always_comb begin
    side_d.src_stride = front.src_stride;
    side_d.plane      = front.plane;
    side_d.bad        = front.bad;
    side_d.dst_offset = nnsa_pkg::sat_offset(nnsa_pkg::SUM_W'(front.dst_prod)
                                             + nnsa_pkg::SUM_W'(front.col));
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      side_q[0] <= side_d;
    end
    for (int k = 1; k < NS; k++) begin
      if (en[k+1]) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  nnsa_offset u_offset (
    .clk_i  (clk_i),
    .en_i   (en[ND-1:ND-2]),
    .col_i  (src_col),
    .row_i  (src_row),
    .side_i (side_q[NS-1]),
    .out_o  (out_data_o)
  );

  `NNSA_ASSERT_NOW(a_reject_zeroes, out_valid_o && out_data_o.out_of_range, (out_data_o.src_col == '0) && (out_data_o.src_row == '0) && (out_data_o.src_offset == '0) && (out_data_o.dst_offset == '0))
  `NNSA_ASSERT_NOW(a_stall_only_full, in_stall_o, valid_q == '1)
  `NNSA_ASSERT_NEXT(a_accept_enters, in_valid_i && !in_stall_o, valid_q[0])
  `NNSA_ASSERT_NOW(a_offset_covers_col, out_valid_o && !out_data_o.out_of_range, out_data_o.src_offset >= nnsa_pkg::OFFSET_W'(out_data_o.src_col))

endmodule

`default_nettype wire
